// ===== rtl/core/pctf_pkg.sv =====
package pctf_pkg;

    localparam int DEF_FIFO_DEPTH = 512;
    localparam int DEF_CHUNK      = 32;

    localparam int BYTE_W   = 8;
    localparam int GAP_W    = 16;
    localparam int FILL_W   = 10;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH = 2'd0,
        OP_TICK = 2'd1,
        OP_SEND = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_CHUNK    = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_WAITING  = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SEND = 1'b1
    } t_state;

endpackage

// ===== rtl/core/paced_chunk_tx_fifo_core.sv =====
// Paced chunk transmit FIFO. Bytes pushed on the input stream (tuser = opcode 0) are queued in a
// single-port-read byte memory; a tick (opcode 1) advances a saturating 16-bit gap counter; a send
// request (opcode 2) answers "empty" or "waiting" in one result, or releases up to CHUNK queued
// bytes, one result per byte, tlast on the final one, and clears the gap counter. A chunk goes out
// only when the gap counter is strictly greater than the min_gap_ticks register, written through
// the cfg channel; the user must write it only while the block is idle, and the block itself does
// not enforce this. After its send transfer, a chunk keeps the input closed while the memory is
// read once per cycle as long as the output does not stall, each byte passing through the registered
// read port into the output register; no input is taken until its last byte is in the output register.
// The memory contents need no clearing after reset.
module paced_chunk_tx_fifo_core
    import pctf_pkg::*;
#(
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH,
    parameter int CHUNK      = DEF_CHUNK
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [GAP_W-1:0]    i_cfg_data,      // min_gap_ticks

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,    // [7:0] push_byte
    input  logic [OPCODE_W-1:0] s_axis_tuser,    // [1:0] opcode

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,    // [7:0] out_byte, [17:8] fill_level, rest zero
    output logic                m_axis_tlast,    // last_of_chunk
    output logic [STATUS_W-1:0] m_axis_tuser     // [2:0] status
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int LW = $clog2(CHUNK + 1);

    logic [BYTE_W-1:0] mem [FIFO_DEPTH];

    t_state            r_state,      n_state;
    logic [PW-1:0]     r_wr_ptr,     n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr,     n_rd_ptr;
    logic [CW-1:0]     r_count,      n_count;
    logic [GAP_W-1:0]  r_gap,        n_gap;
    logic [GAP_W-1:0]  r_min_gap;
    logic [LW-1:0]     r_left,       n_left;
    logic              r_rd_pend,    n_rd_pend;
    logic              r_rd_last,    n_rd_last;
    logic [FILL_W-1:0] r_rd_fill,    n_rd_fill;
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_out_valid,  n_out_valid;
    logic [BYTE_W-1:0] r_out_byte,   n_out_byte;
    logic              r_out_last,   n_out_last;
    t_status           r_out_status, n_out_status;
    logic [FILL_W-1:0] r_out_fill,   n_out_fill;

    logic              out_free;
    logic              in_xfer;
    logic              rd_move;
    logic              rd_issue;
    logic              mem_we;
    t_opcode           in_op;

    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_op         = t_opcode'(s_axis_tuser);
    // read data moves to the output register as soon as it is free
    assign rd_move       = r_rd_pend && out_free;
    assign rd_issue      = (r_state == S_SEND) && (r_left != '0) && (!r_rd_pend || rd_move);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_fill, r_out_byte};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_count      = r_count;
        n_gap        = r_gap;
        n_left       = r_left;
        n_rd_pend    = r_rd_pend;
        n_rd_last    = r_rd_last;
        n_rd_fill    = r_rd_fill;
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        n_out_fill   = r_out_fill;
        mem_we       = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (in_op)
                        OP_PUSH: begin
                            n_out_valid = 1'b1;
                            n_out_byte  = '0;
                            n_out_last  = 1'b0;
                            if (r_count == CW'(FIFO_DEPTH)) begin
                                n_out_status = ST_DROPPED;
                                n_out_fill   = FILL_W'(r_count);
                            end else begin
                                mem_we       = 1'b1;
                                n_wr_ptr     = (r_wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0
                                                                                 : r_wr_ptr + 1'b1;
                                n_count      = r_count + 1'b1;
                                n_out_status = ST_ACCEPTED;
                                n_out_fill   = FILL_W'(r_count + 1'b1);
                            end
                        end
                        OP_TICK: begin
                            if (r_gap != '1) begin
                                n_gap = r_gap + 1'b1;
                            end
                        end
                        OP_SEND: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_byte   = '0;
                                n_out_last   = 1'b0;
                                n_out_status = ST_EMPTY;
                                n_out_fill   = '0;
                            end else if (!(r_gap > r_min_gap)) begin
                                n_out_valid  = 1'b1;
                                n_out_byte   = '0;
                                n_out_last   = 1'b0;
                                n_out_status = ST_WAITING;
                                n_out_fill   = FILL_W'(r_count);
                            end else begin
                                n_left  = (32'(r_count) < 32'(CHUNK)) ? LW'(r_count) : LW'(CHUNK);
                                n_gap   = '0;
                                n_state = S_SEND;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SEND: begin
                if (rd_move) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_rd_data;
                    n_out_last   = r_rd_last;
                    n_out_status = ST_CHUNK;
                    n_out_fill   = r_rd_fill;
                    n_rd_pend    = 1'b0;
                    if (r_left == '0) begin
                        n_state = S_IDLE;
                    end
                end
                if (rd_issue) begin
                    n_rd_pend = 1'b1;
                    n_rd_last = (r_left == LW'(1));
                    n_rd_fill = FILL_W'(r_count - 1'b1);
                    n_count   = r_count - 1'b1;
                    n_rd_ptr  = (r_rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
                    n_left    = r_left - 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_gap       <= '0;
            r_min_gap   <= '0;
            r_left      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_count     <= n_count;
            r_gap       <= n_gap;
            r_left      <= n_left;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_min_gap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last    <= n_rd_last;
        r_rd_fill    <= n_rd_fill;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
        r_out_fill   <= n_out_fill;
    end

    // byte store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wr_ptr] <= s_axis_tdata;
        end
        if (rd_issue) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(FIFO_DEPTH))
        else $error("held count above depth");

    a_send_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> !s_axis_tready)
        else $error("input taken during chunk release");

    a_pend_in_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_pend || r_left != '0) |-> (r_state == S_SEND))
        else $error("read pending outside chunk release");

    a_last_is_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == ST_CHUNK))
        else $error("tlast on a non-chunk result");

    a_send_start_clears_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_SEND) |=> (r_gap == '0 && r_left != '0))
        else $error("chunk start without gap clear");

endmodule

// ===== verif/paced_chunk_tx_fifo_core_tb.sv =====
`timescale 1ns / 1ps

module paced_chunk_tx_fifo_core_tb
    import pctf_pkg::*;
();

    localparam int FIFO_DEPTH = DEF_FIFO_DEPTH;
    localparam int CHUNK      = DEF_CHUNK;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [GAP_W-1:0]    GAP_TOP   = 16'hFFFF;
    localparam int RX_HOLD_CYCLES = 300;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_b;
        logic                last_b;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill;
    } t_out_rec;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [GAP_W-1:0]    i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;    // [7:0] push_byte
    logic [OPCODE_W-1:0] s_axis_tuser;    // [1:0] opcode
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [23:0]         m_axis_tdata;    // [7:0] out_byte, [17:8] fill_level
    logic                m_axis_tlast;    // last_of_chunk
    logic [STATUS_W-1:0] m_axis_tuser;    // [2:0] status

    // predicted block state
    logic [BYTE_W-1:0] tx_bytes[$];
    logic [GAP_W-1:0]  gap_ticks  = '0;
    logic [GAP_W-1:0]  gap_limit  = '0;
    t_out_rec          out_due[$];

    bit tx_idle_en  = 1'b1;
    bit rx_idle_en  = 1'b1;
    bit rx_hold_req = 1'b0;

    int err_count   = 0;
    int n_results   = 0;
    int n_chunks    = 0;
    int n_dropped   = 0;
    int n_waiting   = 0;
    int n_empty     = 0;

    paced_chunk_tx_fifo_core #(
        .FIFO_DEPTH(FIFO_DEPTH),
        .CHUNK     (CHUNK)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void add_out(input logic [7:0] b, input logic last,
                                    input logic [STATUS_W-1:0] st);
        t_out_rec r;
        r.data_b = b;
        r.last_b = last;
        r.status = st;
        r.fill   = FILL_W'(tx_bytes.size());
        out_due.push_back(r);
    endfunction

    function automatic void apply_fifo_op(input logic [1:0] op, input logic [7:0] b);
        int n;
        case (op)
            OP_PUSH: begin
                if (tx_bytes.size() >= FIFO_DEPTH) begin
                    add_out(8'd0, 1'b0, ST_DROPPED);
                end else begin
                    tx_bytes.push_back(b);
                    add_out(8'd0, 1'b0, ST_ACCEPTED);
                end
            end
            OP_TICK: begin
                if (gap_ticks != GAP_TOP) gap_ticks = gap_ticks + 1'b1;
            end
            OP_SEND: begin
                if (tx_bytes.size() == 0) begin
                    add_out(8'd0, 1'b0, ST_EMPTY);
                end else if (gap_ticks <= gap_limit) begin
                    add_out(8'd0, 1'b0, ST_WAITING);
                end else begin
                    n = (tx_bytes.size() < CHUNK) ? tx_bytes.size() : CHUNK;
                    for (int i = 0; i < n; i++)
                        add_out(tx_bytes.pop_front(), i == n - 1, ST_CHUNK);
                    gap_ticks = '0;
                end
            end
            default: ;  // unused opcode: no effect
        endcase
    endfunction

    // one input transfer; valid stays high across back-to-back calls unless a random idle gap is inserted
    task automatic send_item(input logic [1:0] op, input logic [7:0] data);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        apply_fifo_op(op, data);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (out_due.size() > 0) @(posedge i_clk);
        // ticks give no result; allow a full chunk time to settle
        repeat (CHUNK + 8) @(posedge i_clk);
    endtask

    task automatic write_gap_limit(input logic [GAP_W-1:0] v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        gap_limit = v;
    endtask

    task automatic test_basic_ops();
        send_item(OP_SEND, 8'hFF);          // empty
        send_item(OP_PUSH, 8'h00);
        send_item(OP_SEND, 8'h00);          // counter 0, not past limit 0
        send_item(OP_TICK, 8'hFF);
        send_item(OP_SEND, 8'h00);          // one-byte chunk
        send_item(OP_SEND, 8'h00);          // empty again
        send_item(OP_UNUSED, 8'hA5);
        send_item(OP_PUSH, 8'hFF);
        send_item(OP_PUSH, 8'h5A);
        send_item(OP_PUSH, 8'hA5);
        send_item(OP_UNUSED, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_SEND, 8'h00);
        write_gap_limit(16'd2);
        send_item(OP_PUSH, 8'h81);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_SEND, 8'h00);          // 2 ticks, limit 2: waits
        send_item(OP_TICK, 8'h00);
        send_item(OP_SEND, 8'h00);
    endtask

    task automatic test_fill_and_drop();
        write_gap_limit(16'd1);
        while (tx_bytes.size() < FIFO_DEPTH)
            send_item(OP_PUSH, 8'($urandom_range(0, 255)));
        send_item(OP_PUSH, 8'h7E);
        send_item(OP_PUSH, 8'h18);
        send_item(OP_SEND, 8'h00);
        while (tx_bytes.size() > 0) begin
            repeat (gap_limit + 1) send_item(OP_TICK, 8'($urandom_range(0, 255)));
            send_item(OP_SEND, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_gap_saturation();
        bit saved_idle;
        saved_idle = tx_idle_en;
        write_gap_limit(GAP_TOP - 1'b1);
        send_item(OP_PUSH, 8'h3C);
        send_item(OP_PUSH, 8'hC3);
        tx_idle_en = 1'b0;
        // one past the counter range: a wrapped counter would fail the send below
        for (int k = 0; k <= int'(GAP_TOP); k++) send_item(OP_TICK, 8'h00);
        send_item(OP_SEND, 8'h00);
        write_gap_limit(GAP_TOP);
        send_item(OP_PUSH, 8'h96);
        for (int k = 0; k <= int'(GAP_TOP); k++) send_item(OP_TICK, 8'h00);
        tx_idle_en = saved_idle;
        send_item(OP_SEND, 8'h00);          // saturated counter still not past limit
        write_gap_limit(16'd0);
        send_item(OP_TICK, 8'h00);
        send_item(OP_SEND, 8'h00);
    endtask

    task automatic test_output_hold();
        write_gap_limit(16'd0);
        rx_hold_req = 1'b1;
        repeat (40) send_item(OP_PUSH, 8'($urandom_range(0, 255)));
        send_item(OP_TICK, 8'h00);
        send_item(OP_SEND, 8'h00);
        repeat (6) send_item(OP_PUSH, 8'($urandom_range(0, 255)));
        send_item(OP_TICK, 8'h00);
        send_item(OP_SEND, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_SEND, 8'h00);
    endtask

    task automatic run_mixed_traffic(input int n_items);
        int r;
        int burst;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                send_item(OP_PUSH, 8'($urandom_range(0, 255)));
            end else if (r < 72) begin
                burst = $urandom_range(1, gap_limit + 2);
                repeat (burst) send_item(OP_TICK, 8'($urandom_range(0, 255)));
            end else if (r < 95) begin
                send_item(OP_SEND, 8'($urandom_range(0, 255)));
            end else begin
                send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_random_phases();
        write_gap_limit(16'd1);
        run_mixed_traffic(50);
        rx_idle_en = 1'b0;
        write_gap_limit(16'd0);
        run_mixed_traffic(40);
        rx_idle_en = 1'b1;
        write_gap_limit(16'd4);
        run_mixed_traffic(50);
        // closing stretch at full rate on both sides
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_gap_limit(16'd2);
        run_mixed_traffic(40);
    endtask

    // receiver backpressure
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (int c = 0; c < RX_HOLD_CYCLES; c++) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // result checker
    always begin
        t_out_rec got;
        t_out_rec want;
        @(posedge i_clk);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.data_b = m_axis_tdata[7:0];
            got.fill   = m_axis_tdata[17:8];
            got.last_b = m_axis_tlast;
            got.status = m_axis_tuser;
            #1;  // let an input taken on the same edge update the prediction
            if (out_due.size() == 0) begin
                $error("result transfer with nothing expected: status %0d", got.status);
                err_count++;
            end else begin
                want = out_due.pop_front();
                n_results++;
                if (got.data_b !== want.data_b) begin
                    $error("out_byte: expected %0h, actual %0h", want.data_b, got.data_b);
                    err_count++;
                end
                if (got.last_b !== want.last_b) begin
                    $error("last_of_chunk: expected %0d, actual %0d", want.last_b, got.last_b);
                    err_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    err_count++;
                end
                if (got.fill !== want.fill) begin
                    $error("fill_level: expected %0d, actual %0d", want.fill, got.fill);
                    err_count++;
                end
                case (want.status)
                    ST_DROPPED: n_dropped++;
                    ST_WAITING: n_waiting++;
                    ST_EMPTY:   n_empty++;
                    ST_CHUNK:   if (want.last_b) n_chunks++;
                    default: ;
                endcase
            end
        end
    end

    initial begin
        #50_000_000;
        $display("paced_chunk_tx_fifo_core_tb: done, errors");
        $finish;
    end

    initial begin
        int settle;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_fill_and_drop();
        test_gap_saturation();
        test_output_hold();
        test_random_phases();

        s_axis_tvalid <= 1'b0;
        settle = 0;
        while (out_due.size() > 0 && settle < 20000) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (CHUNK + 8) @(posedge i_clk);
        if (out_due.size() > 0) begin
            $error("%0d expected results never arrived", out_due.size());
            err_count++;
        end

        $display("covered %0d results: %0d chunks, %0d dropped pushes, %0d early sends,",
                 n_results, n_chunks, n_dropped, n_waiting);
        $display("%0d empty sends, gap limits 0 to 65535, full FIFO and long output stall",
                 n_empty);
        if (err_count == 0) begin
            $display("paced_chunk_tx_fifo_core_tb: done, clean");
        end else begin
            $display("paced_chunk_tx_fifo_core_tb: done, errors");
        end
        $finish;
    end

endmodule
